// ----- rtl/pixel_readout_word_decoder_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the readout word decoder
// ---------------------------------------------------------------------------
`ifndef PIXEL_READOUT_WORD_DECODER_CORE_MACROS_SVH
`define PIXEL_READOUT_WORD_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define PRWD_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define PRWD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// ----- rtl/prwd_pkg.sv -----
// ---------------------------------------------------------------------------
// prwd_pkg
// Types, codes and helpers shared by the readout word decoder modules.
// ---------------------------------------------------------------------------
package prwd_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int CFG_W           = 9;

	typedef enum logic [3:0] {
		KIND_HIT       = 4'd0,
		KIND_CHIP_TS   = 4'd1,
		KIND_TRIG_LOW  = 4'd2,
		KIND_TRIG_HIGH = 4'd3,
		KIND_TS_MID    = 4'd4,
		KIND_TS_LOW    = 4'd5,
		KIND_BUSY      = 4'd6,
		KIND_T0        = 4'd7,
		KIND_EMPTY     = 4'd8,
		KIND_LOCK      = 4'd9,
		KIND_LOCK_LOST = 4'd10,
		KIND_WEIRD     = 4'd11,
		KIND_UNKNOWN   = 4'd12
	} kind_t;

	localparam logic [7:0] MT_CHIP_TS   = 8'h40;
	localparam logic [7:0] MT_TRIG_LOW  = 8'h10;
	localparam logic [7:0] MT_TRIG_HIGH = 8'h30;
	localparam logic [7:0] MT_TS_MID    = 8'h20;
	localparam logic [7:0] MT_TS_LOW    = 8'h60;
	localparam logic [7:0] MT_BUSY      = 8'h02;
	localparam logic [7:0] MT_T0        = 8'h70;
	localparam logic [7:0] MT_EMPTY     = 8'h00;

	typedef struct packed {
		kind_t        kind;
		logic [5:0]   column;
		logic [8:0]   row;
		logic [63:0]  event_time;
		logic [5:0]   fine;
		logic [31:0]  trigger_number;
		logic         ovf_flag;
		logic         fragment_repaired;
	} item_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_DIV  = 2'd1,
		BK_FIN  = 2'd2
	} back_state_t;

	// each output bit is the parity of the gray bits at and above it
	function automatic logic [9:0] gray_to_bin(input logic [9:0] g);
		logic [9:0] b;
		for (int i = 0; i < 10; i++) begin
			b[i] = ^(g >> i);
		end
		return b;
	endfunction

endpackage

// ----- rtl/prwd_front.sv -----
// ---------------------------------------------------------------------------
// prwd_front
// Classifies readout words, keeps the time and trigger state, emits items.
// ---------------------------------------------------------------------------
module prwd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 word_valid,
	input  logic [31:0]          word,
	output prwd_pkg::item_t      item
);

	logic [63:0] readout_q, board_q, top_q, mid_q;
	logic [23:0] low_q;
	logic        top_fresh_q, mid_fresh_q;
	logic [31:0] trig_q;

	logic [63:0] readout_d, board_d, top_d, mid_d;
	logic [23:0] low_d;
	logic        top_fresh_d, mid_fresh_d;
	logic [31:0] trig_d;

	logic [7:0]         mt;
	logic [10:0]        coarse;
	logic [9:0]         fine_bin;
	logic signed [12:0] hd;
	logic [16:0]        chip;
	logic signed [18:0] cd;
	logic [63:0]        x_mid;

	always_comb begin
		readout_d   = readout_q;
		board_d     = board_q;
		top_d       = top_q;
		mid_d       = mid_q;
		low_d       = low_q;
		top_fresh_d = top_fresh_q;
		mid_fresh_d = mid_fresh_q;
		trig_d      = trig_q;
		mt          = word[31:24];
		coarse      = {prwd_pkg::gray_to_bin(word[15:6]), 1'b0};
		fine_bin    = prwd_pkg::gray_to_bin({4'd0, word[5:0]});
		hd          = $signed({2'b00, coarse}) - $signed({2'b00, readout_q[10:0]});
		chip        = {word[23:8], 1'b0};
		cd          = $signed({2'b00, chip}) - $signed({2'b00, board_q[16:0]});
		x_mid       = {16'd0, word[23:0], 24'd0};

		item                   = '0;
		item.kind              = prwd_pkg::KIND_UNKNOWN;

		if (word[31]) begin
			if (hd > 13'sd511) begin
				hd = hd - 13'sd2048;
			end else if (hd < -13'sd1537) begin
				hd = hd + 13'sd2048;
			end
			item.kind       = prwd_pkg::KIND_HIT;
			item.row        = word[24:16];
			item.column     = word[30:25];
			item.fine       = fine_bin[5:0];
			item.event_time = readout_q + {{51{hd[12]}}, hd};
		end else begin
			item.ovf_flag = ((mt & 8'hF3) == 8'h01);
			unique case (mt)
				prwd_pkg::MT_CHIP_TS: begin
					if (cd > 19'sd65536) begin
						cd = cd - 19'sd131072;
					end else if (cd < -19'sd4096) begin
						cd = cd + 19'sd131072;
					end
					readout_d       = board_q + {{45{cd[18]}}, cd};
					item.event_time = readout_d;
					item.kind       = prwd_pkg::KIND_CHIP_TS;
				end
				prwd_pkg::MT_TRIG_LOW: begin
					trig_d    = {8'd0, word[23:0]};
					item.kind = prwd_pkg::KIND_TRIG_LOW;
				end
				prwd_pkg::MT_TRIG_HIGH: begin
					trig_d      = trig_q | {word[23:16], 24'd0};
					top_d       = {word[15:0], 48'd0};
					top_fresh_d = 1'b1;
					item.kind   = prwd_pkg::KIND_TRIG_HIGH;
				end
				prwd_pkg::MT_TS_MID: begin
					if (!top_fresh_q && x_mid < mid_q) begin
						top_d                  = top_q + 64'h0001_0000_0000_0000;
						item.fragment_repaired = 1'b1;
					end
					top_fresh_d = 1'b0;
					mid_fresh_d = 1'b1;
					mid_d       = x_mid;
					item.kind   = prwd_pkg::KIND_TS_MID;
				end
				prwd_pkg::MT_TS_LOW: begin
					if (!mid_fresh_q && word[23:0] < low_q) begin
						mid_d                  = mid_q + 64'h0000_0000_0100_0000;
						item.fragment_repaired = 1'b1;
					end
					mid_fresh_d     = 1'b0;
					low_d           = word[23:0];
					board_d         = top_q | mid_d | {40'd0, word[23:0]};
					item.event_time = board_d;
					item.kind       = prwd_pkg::KIND_TS_LOW;
				end
				prwd_pkg::MT_BUSY:  item.kind = prwd_pkg::KIND_BUSY;
				prwd_pkg::MT_T0:    item.kind = prwd_pkg::KIND_T0;
				prwd_pkg::MT_EMPTY: item.kind = prwd_pkg::KIND_EMPTY;
				default: begin
					if ((mt & 8'hF2) != 8'h00) begin
						item.kind = prwd_pkg::KIND_UNKNOWN;
					end else if ((mt & 8'hFE) == 8'h08) begin
						item.kind = prwd_pkg::KIND_LOCK;
					end else if ((mt & 8'hFE) == 8'h0C) begin
						item.kind = prwd_pkg::KIND_LOCK_LOST;
					end else if ((mt & 8'hFE) == 8'h04) begin
						item.kind = prwd_pkg::KIND_WEIRD;
					end else begin
						item.kind = prwd_pkg::KIND_UNKNOWN;
					end
				end
			endcase
		end
		item.trigger_number = trig_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			readout_q   <= '0;
			board_q     <= '0;
			top_q       <= '0;
			mid_q       <= '0;
			low_q       <= '0;
			top_fresh_q <= 1'b1;
			mid_fresh_q <= 1'b1;
			trig_q      <= '0;
		end else if (word_valid) begin
			readout_q   <= readout_d;
			board_q     <= board_d;
			top_q       <= top_d;
			mid_q       <= mid_d;
			low_q       <= low_d;
			top_fresh_q <= top_fresh_d;
			mid_fresh_q <= mid_fresh_d;
			trig_q      <= trig_d;
		end
	end

endmodule

// ----- rtl/prwd_fifo.sv -----
// ---------------------------------------------------------------------------
// prwd_fifo
// Short item queue between front and back, fall-through read.
// ---------------------------------------------------------------------------
module prwd_fifo #(
	parameter int DEPTH = prwd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  prwd_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output prwd_pkg::item_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	prwd_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/prwd_back.sv -----
// ---------------------------------------------------------------------------
// prwd_back
// Drains the queue; hits go through a bit-serial divider for time over
// threshold before the output register.
// ---------------------------------------------------------------------------
module prwd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [prwd_pkg::CFG_W-1:0]   divider,
	input  logic                         q_empty,
	input  prwd_pkg::item_t              q_head,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output prwd_pkg::item_t              out_item,
	output logic [5:0]                   out_tot
);

	prwd_pkg::back_state_t state_q, state_d;

	prwd_pkg::item_t            hold_q;
	logic [63:0]                dvd_q;
	logic [prwd_pkg::CFG_W-1:0] dsr_q;
	logic [prwd_pkg::CFG_W-1:0] rem_q;
	logic [5:0]                 quo_q;
	logic [5:0]                 cnt_q;
	logic                       ovalid_q;

	logic                     out_free;
	logic                     head_hit;
	logic                     load_div, load_direct, load_fin, step;
	logic [prwd_pkg::CFG_W:0] rem_sh;
	logic                     ge;

	assign out_free = !ovalid_q || out_ready;
	assign head_hit = (q_head.kind == prwd_pkg::KIND_HIT);
	assign rem_sh   = {rem_q, dvd_q[63]};
	assign ge       = (rem_sh >= {1'b0, dsr_q});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prwd_pkg::BK_IDLE: if (!q_empty && head_hit) state_d = prwd_pkg::BK_DIV;
			prwd_pkg::BK_DIV:  if (cnt_q == 6'd63) state_d = prwd_pkg::BK_FIN;
			prwd_pkg::BK_FIN:  if (out_free) state_d = prwd_pkg::BK_IDLE;
			default:           state_d = prwd_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		load_div    = 1'b0;
		load_direct = 1'b0;
		load_fin    = 1'b0;
		step        = 1'b0;
		unique case (state_q)
			prwd_pkg::BK_IDLE: begin
				load_div    = !q_empty && head_hit;
				load_direct = !q_empty && !head_hit && out_free;
			end
			prwd_pkg::BK_DIV: step     = 1'b1;
			prwd_pkg::BK_FIN: load_fin = out_free;
			default: ;
		endcase
		q_pop = load_div || load_direct;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= prwd_pkg::BK_IDLE;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (load_direct || load_fin) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (load_div) begin
				cnt_q <= '0;
			end else if (step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_div) begin
			hold_q <= q_head;
			dvd_q  <= q_head.event_time;
			dsr_q  <= (divider == '0) ? prwd_pkg::CFG_W'(1) : divider;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			rem_q <= ge ? prwd_pkg::CFG_W'(rem_sh - {1'b0, dsr_q})
			            : rem_sh[prwd_pkg::CFG_W-1:0];
			quo_q <= {quo_q[4:0], ge};
		end
		if (load_direct) begin
			out_item <= q_head;
			out_tot  <= '0;
		end else if (load_fin) begin
			out_item <= hold_q;
			out_tot  <= hold_q.fine - quo_q;
		end
	end

	assign out_valid = ovalid_q;

endmodule

// ----- rtl/pixel_readout_word_decoder_core.sv -----
// Path: non-hit words pass through the item queue and the output register;
// hits go through load, the 64-step bit-serial divider and the output load.
// Throughput: one non-hit item per cycle unless the output stalls; a hit holds the
// back end to its output load, while the queue lets the front accept until it fills.
// Reset: asynchronous, active low; clears all time/trigger state, divider to 1.
// ---------------------------------------------------------------------------
// pixel_readout_word_decoder_core
// Top level: front classifier, item queue, back end with divider.
// ---------------------------------------------------------------------------
module pixel_readout_word_decoder_core #(
	parameter int QUEUE_DEPTH = prwd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,   // data_word
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// column, row, event_time, over_threshold, trigger_number,
	// overflow flag, fragment_repaired, one pad bit
	output logic [119:0]               m_tdata,
	output logic [3:0]                 m_tuser,   // kind
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [prwd_pkg::CFG_W-1:0] cfg_data   // tot_clock_divider
);

	logic [prwd_pkg::CFG_W-1:0] div_q;
	prwd_pkg::item_t            f_item, q_head, o_item;
	logic                       q_full, q_empty, q_pop, accept;
	logic [5:0]                 o_tot;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= prwd_pkg::CFG_W'(1);
		end else if (cfg_valid) begin
			div_q <= cfg_data;
		end
	end

	prwd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (accept),
		.word       (s_tdata),
		.item       (f_item)
	);

	prwd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (f_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	prwd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.divider   (div_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (o_item),
		.out_tot   (o_tot)
	);

	assign m_tuser = o_item.kind;
	assign m_tdata = {1'b0, o_item.fragment_repaired, o_item.ovf_flag,
		o_item.trigger_number, o_tot, o_item.event_time, o_item.row, o_item.column};

endmodule

// ----- rtl/prwd_checker.sv -----
// ---------------------------------------------------------------------------
// prwd_checker
// Port-level checks on the decoder's result stream.
// ---------------------------------------------------------------------------
`include "pixel_readout_word_decoder_core_macros.svh"

module prwd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata,
	input logic [3:0]   m_tuser
);

	logic is_hit, is_ts_frag;

	assign is_hit     = (m_tuser == prwd_pkg::KIND_HIT);
	assign is_ts_frag = (m_tuser == prwd_pkg::KIND_TS_MID) || (m_tuser == prwd_pkg::KIND_TS_LOW);

	`PRWD_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`PRWD_ASSERT_IMPLY(a_addr_zero, clk, arst_n, m_tvalid && !is_hit, m_tdata[14:0] == 15'd0)
	`PRWD_ASSERT_IMPLY(a_ovf_kind, clk, arst_n, m_tvalid && m_tdata[117], !is_hit)
	`PRWD_ASSERT_IMPLY(a_rep_kind, clk, arst_n, m_tvalid && m_tdata[118], is_ts_frag)

endmodule

bind pixel_readout_word_decoder_core prwd_checker u_prwd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
